FILE: rtl/uwms_pkg.sv
// shared constants and types for the ungapped window match scorer
// no dependencies; imported by every module of the block
package uwms_pkg;

  localparam int DEF_MAX_PATTERN   = 16;
  localparam int DEF_POSITION_BITS = 32;

  localparam int SYM_W       = 8;
  localparam int SCORE_W     = 7;
  localparam int LOC_W       = 32;
  localparam int LEN_REG_W   = 5;
  localparam int CFG_W       = 64;
  localparam int PADDR_W     = 5;
  localparam int GRP_SIZE    = 8;
  localparam int GRP_CNT_W   = 4;
  localparam int LEN_RESET   = 3;
  localparam int PAT_STORED  = 16;

  localparam int MATCH_SCORE    = 1;
  localparam int MISMATCH_SCORE = -3;
  localparam int SCORE_HI       = 63;
  localparam int SCORE_LO       = -64;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_LOW    = 2'd1,
    REG_HIGH   = 2'd2
  } cfg_reg_t;

  // controls shared by the whole row of window cells
  typedef struct packed {
    logic shift;    // a word is accepted this cycle
    logic clear;    // that word ends the sequence
    logic advance;  // pipeline moves this cycle
  } cell_ctrl_t;

  // per-word flags traveling down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic full;     // a whole window is present
  } stage_t;

endpackage

FILE: rtl/uwms_cell.sv
// one window position: holds a sequence byte and registers its compare
// against the pattern symbol lined up with it; uses uwms_pkg
module uwms_cell
  import uwms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [SYM_W-1:0] byte_in,
  input  logic [SYM_W-1:0] pat_sym,
  input  logic             active,
  output logic [SYM_W-1:0] byte_out,
  output logic             match
);

  logic [SYM_W-1:0] held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctrl.shift) begin
      held <= ctrl.clear ? '0 : byte_in;
    end
  end

  // compare uses the byte as it stands after the shift
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.advance) begin
      match <= ctrl.shift && active && (byte_in == pat_sym);
    end
  end

  assign byte_out = held;

endmodule

FILE: rtl/uwms_best.sv
// final stage: totals the match counts, scores the window, tracks the best
// one and holds the result word; uses uwms_pkg
module uwms_best
  import uwms_pkg::*;
#(
  parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  stage_t                              stage,
  input  logic [POSITION_BITS-1:0]            start,
  input  logic [GRP_CNT_W-1:0]                grp_cnt [(MAX_PATTERN+GRP_SIZE-1)/GRP_SIZE],
  input  logic [$clog2(MAX_PATTERN+1)-1:0]    plen,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [SCORE_W-1:0]           out_score,
  output logic [LOC_W-1:0]                    out_loc,
  output logic                                out_no_window
);

  localparam int NGRP   = (MAX_PATTERN + GRP_SIZE - 1) / GRP_SIZE;
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int SC_W   = LEN_W + 4;

  logic signed [SCORE_W-1:0] best;
  logic [LOC_W-1:0]          best_loc;
  logic                      have;

  logic [LEN_W-1:0]          total;
  logic signed [SC_W-1:0]    m_s;
  logic signed [SC_W-1:0]    p_s;
  logic signed [SC_W-1:0]    score;
  logic signed [SCORE_W-1:0] score_sat;
  logic                      take;
  logic signed [SCORE_W-1:0] best_next;
  logic [LOC_W-1:0]          loc_next;
  logic                      have_next;

  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + LEN_W'(grp_cnt[g]);
    end
  end

  always_comb begin
    m_s   = SC_W'(total);
    p_s   = SC_W'(plen);
    score = SC_W'(MATCH_SCORE) * m_s + SC_W'(MISMATCH_SCORE) * (p_s - m_s);
    if (score > SC_W'(SCORE_HI)) begin
      score_sat = SCORE_W'(SCORE_HI);
    end else if (score < SC_W'(SCORE_LO)) begin
      score_sat = SCORE_W'(SCORE_LO);
    end else begin
      score_sat = score[SCORE_W-1:0];
    end
    // ties go to the later window
    take      = stage.full && (!have || (score_sat >= best));
    best_next = take ? score_sat : best;
    loc_next  = take ? LOC_W'(start) : best_loc;
    have_next = have || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best     <= '0;
      best_loc <= '0;
      have     <= 1'b0;
    end else if (advance && stage.valid) begin
      if (stage.last) begin
        best     <= '0;
        best_loc <= '0;
        have     <= 1'b0;
      end else begin
        best     <= best_next;
        best_loc <= loc_next;
        have     <= have_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage.valid && stage.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.valid && stage.last) begin
      out_score     <= have_next ? best_next : '0;
      out_loc       <= have_next ? loc_next : '0;
      out_no_window <= !have_next;
    end
  end

endmodule

FILE: rtl/ungapped_window_match_scorer_core.sv
// top level of the ungapped window match scorer
// depends on uwms_pkg, uwms_cell and uwms_best
//
// Sequence bytes enter on s_axis one word per cycle; s_axis_tlast marks the
// final byte. A row of MAX_PATTERN cells holds the latest bytes, newest in
// cell 0, and every cell compares its byte with the pattern symbol that lines
// up with it for the current pattern length. Each full window scores +1 per
// matching position and -3 per mismatch; the best score and the start index
// of the latest window that reached it are kept. After the last byte one
// result word leaves on m_axis: tdata carries best_score and best_location,
// tuser carries no_window, set when the sequence was shorter than the
// pattern. Throughput is one byte per clock while s_axis_tready is high, held
// by the shift and compare of the cell row; a result appears on m_axis once
// its last byte has passed the cell compare registered at the accepting edge,
// then the group count, then the score and best update. Input is stalled
// only while a finished last word would overwrite a result that m_axis has
// not yet taken. Configuration sits on an APB port
// with 64-bit registers at 0x00 (pattern_length), 0x08 (pattern symbols 0 to
// 7) and 0x10 (symbols 8 to 15); write it only while no word is in flight.
// No clearing pass is needed after reset.
module ungapped_window_match_scorer_core
  import uwms_pkg::*;
#(
  parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // sequence input
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] symbol
  input  logic               s_axis_tlast,   // last
  // result output
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,   // [6:0] best_score, [38:7] best_location, [39] zero
  output logic               m_axis_tuser,   // [0] no_window
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int NGRP  = (MAX_PATTERN + GRP_SIZE - 1) / GRP_SIZE;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // configuration registers
  logic [LEN_REG_W-1:0] len_reg;
  logic [CFG_W-1:0]     pat_low;
  logic [CFG_W-1:0]     pat_high;
  cfg_reg_t             cfg_sel;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg  <= LEN_REG_W'(LEN_RESET);
      pat_low  <= '0;
      pat_high <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LENGTH: len_reg  <= pwdata[LEN_REG_W-1:0];
        REG_LOW:    pat_low  <= pwdata;
        REG_HIGH:   pat_high <= pwdata;
        default:    ;  // address beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_LENGTH: prdata = CFG_W'(len_reg);
      REG_LOW:    prdata = pat_low;
      REG_HIGH:   prdata = pat_high;
      default:    prdata = '0;
    endcase
  end

  // effective pattern length, clamped to 1..MAX_PATTERN
  logic [LEN_W-1:0] plen;

  always_comb begin
    if (len_reg == '0) begin
      plen = LEN_W'(1);
    end else if (32'(len_reg) > MAX_PATTERN) begin
      plen = LEN_W'(MAX_PATTERN);
    end else begin
      plen = LEN_W'(len_reg);
    end
  end

  // pattern symbols by position; positions past the stored sixteen read zero
  logic [SYM_W-1:0] pat_sym [MAX_PATTERN];

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < 8) begin : g_lo
      assign pat_sym[k] = pat_low[SYM_W*k +: SYM_W];
    end else if (k < PAT_STORED) begin : g_hi
      assign pat_sym[k] = pat_high[SYM_W*(k-8) +: SYM_W];
    end else begin : g_zero
      assign pat_sym[k] = '0;
    end
  end

  // pipeline moves unless a finished sequence is blocked by a waiting result
  stage_t     a_stage;
  stage_t     b_stage;
  logic       advance;
  logic       accept;
  cell_ctrl_t ctrl;

  assign advance       = !(b_stage.valid && b_stage.last && m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ctrl.shift   = accept;
  assign ctrl.clear   = accept && s_axis_tlast;
  assign ctrl.advance = advance;

  // saturating position counter
  logic [POSITION_BITS-1:0] seen;
  logic [POSITION_BITS-1:0] seen_next;
  logic [POSITION_BITS-1:0] plen_pos;
  logic [POSITION_BITS-1:0] a_start;

  assign seen_next = (seen == POS_MAX) ? seen : seen + POSITION_BITS'(1);
  assign plen_pos  = POSITION_BITS'(plen);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= s_axis_tlast ? '0 : seen_next;
    end
  end

  // stage a: flags alongside the registered compares in the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      a_stage <= '0;
    end else if (advance) begin
      a_stage.valid <= accept;
      a_stage.last  <= s_axis_tlast;
      a_stage.full  <= seen_next >= plen_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_start <= seen_next - plen_pos;
    end
  end

  // row of window cells, each byte handed to the next cell on every accepted word but the last, which clears the row
  logic [SYM_W-1:0] cell_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] match;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [SYM_W-1:0] byte_in;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] pos;
    logic             active;

    if (i == 0) begin : g_head
      assign byte_in = s_axis_tdata;
    end else begin : g_link
      assign byte_in = cell_byte[i-1];
    end

    // cell i holds the byte that meets pattern symbol plen-1-i
    always_comb begin
      active = LEN_W'(i) < plen;
      pos    = plen - LEN_W'(1) - LEN_W'(i);
      sym    = active ? pat_sym[pos[IDX_W-1:0]] : '0;
    end

    uwms_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .byte_in  (byte_in),
      .pat_sym  (sym),
      .active   (active),
      .byte_out (cell_byte[i]),
      .match    (match[i])
    );
  end

  // stage b: match counts per group of eight cells
  logic [GRP_CNT_W-1:0]     grp_cnt [NGRP];
  logic [GRP_CNT_W-1:0]     b_grp   [NGRP];
  logic [POSITION_BITS-1:0] b_start;

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_cnt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < MAX_PATTERN) begin
          grp_cnt[g] = grp_cnt[g] + GRP_CNT_W'(match[g * GRP_SIZE + k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        b_grp[g] <= grp_cnt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_stage <= '0;
    end else if (advance) begin
      b_stage <= a_stage;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_start <= a_start;
    end
  end

  // scoring, best tracking and the result word
  logic signed [SCORE_W-1:0] out_score;
  logic [LOC_W-1:0]          out_loc;
  logic                      out_no_window;

  uwms_best #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_best (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .stage         (b_stage),
    .start         (b_start),
    .grp_cnt       (b_grp),
    .plen          (plen),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_score     (out_score),
    .out_loc       (out_loc),
    .out_no_window (out_no_window)
  );

  assign m_axis_tdata = {1'b0, out_loc, out_score};
  assign m_axis_tuser = out_no_window;

endmodule

FILE: tb/ungapped_window_match_scorer_core_test.sv
// self-checking bench for the ungapped window match scorer core
// needs uwms_pkg and the core; streams sequence words, checks result words
`timescale 1ns / 1ps

module ungapped_window_match_scorer_core_test;
  import uwms_pkg::*;

  localparam int MAX_PAT      = DEF_MAX_PATTERN;
  localparam int RANDOM_WORDS = 1350;
  localparam int DRAIN_CYCLES = 8;       // settle time once every result is back
  localparam int HOLD_CYCLES  = 250;     // long receiver hold-off for back pressure
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_CAP   = 40;

  // 64-bit registers sit on 8-byte strides, index in paddr[4:3]
  localparam logic [PADDR_W-1:0] ADDR_LENGTH = {REG_LENGTH, 3'b000};
  localparam logic [PADDR_W-1:0] ADDR_LOW    = {REG_LOW, 3'b000};
  localparam logic [PADDR_W-1:0] ADDR_HIGH   = {REG_HIGH, 3'b000};
  localparam logic [PADDR_W-1:0] ADDR_SPARE  = {2'd3, 3'b000};  // no register here

  typedef struct {
    logic [7:0]  symbol;
    logic        last;
    int unsigned gap;      // idle cycles before the word is offered
  } seq_word_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [LOC_W-1:0]   location;
    logic               no_window;
  } result_t;

  // dut ports, all inputs known from time zero
  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = 8'h00;   // [7:0] symbol
  logic               s_axis_tlast  = 1'b0;    // last
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;            // [6:0] best_score, [38:7] best_location, [39] zero
  logic               m_axis_tuser;            // [0] no_window
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [CFG_W-1:0]   pwdata        = '0;
  logic [CFG_W-1:0]   prdata;
  logic               pready;

  ungapped_window_match_scorer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // scoring model: shadow registers plus window, count and best tracking
  // ---------------------------------------------------------------------
  logic [LEN_REG_W-1:0] len_reg = LEN_RESET[LEN_REG_W-1:0];
  logic [CFG_W-1:0]     pat_lo  = '0;
  logic [CFG_W-1:0]     pat_hi  = '0;

  logic [7:0]       recent [MAX_PAT] = '{default: 8'h00};  // newest byte at index 0
  logic [LOC_W-1:0] seen_count  = '0;                      // saturating byte count
  int               best_total  = 0;
  logic [LOC_W-1:0] best_at     = '0;
  bit               window_seen = 1'b0;

  result_t   pending_results [$];   // scores still owed by the core
  seq_word_t seq_words [$];         // words waiting for the driver

  int  words_pushed   = 0;
  int  words_offered  = 0;
  int  words_in       = 0;
  int  words_out      = 0;
  int  mismatches     = 0;
  int  settings_used  = 0;
  int  cycle_count    = 0;
  int  tx_gap_max     = 0;
  int  rx_gap_max     = 0;
  int  hold_requests  = 0;

  // length register as the core uses it: zero reads as one, clamp at the row size
  function automatic int active_length();
    int n;
    n = int'(len_reg);
    if (n < 1) n = 1;
    if (n > MAX_PAT) n = MAX_PAT;
    return n;
  endfunction

  function automatic logic [7:0] pattern_byte(input int j);
    if (j < GRP_SIZE) return pat_lo[8*j +: 8];
    return pat_hi[8*(j-GRP_SIZE) +: 8];
  endfunction

  // take one accepted word, score the window it completes, queue a result on last
  task automatic score_window_word(input logic [7:0] sym, input logic last);
    int n;
    int total;
    result_t r;
    n = active_length();
    for (int i = MAX_PAT - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = sym;
    if (seen_count != '1) seen_count++;
    if (seen_count >= LOC_W'(n)) begin
      total = 0;
      // pattern symbol j lines up with the byte n-1-j words back
      for (int j = 0; j < n; j++)
        total += (recent[n-1-j] == pattern_byte(j)) ? MATCH_SCORE : MISMATCH_SCORE;
      if (total > SCORE_HI) total = SCORE_HI;
      if (total < SCORE_LO) total = SCORE_LO;
      // ties go to the later window
      if (!window_seen || total >= best_total) begin
        best_total  = total;
        best_at     = seen_count - LOC_W'(n);
        window_seen = 1'b1;
      end
    end
    if (last) begin
      if (window_seen) begin
        r.score     = best_total[SCORE_W-1:0];
        r.location  = best_at;
        r.no_window = 1'b0;
      end else begin
        // sequence never filled a window
        r.score     = '0;
        r.location  = '0;
        r.no_window = 1'b1;
      end
      pending_results.push_back(r);
      recent      = '{default: 8'h00};
      seen_count  = '0;
      best_total  = 0;
      best_at     = '0;
      window_seen = 1'b0;
    end
  endtask

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_word(input logic [7:0] sym, input logic last);
    seq_word_t w;
    w.symbol = sym;
    w.last   = last;
    w.gap    = $urandom_range(0, tx_gap_max);
    seq_words.push_back(w);
    words_pushed++;
  endtask

  // everything accepted, every result back, pipeline given time to settle
  task automatic wait_idle();
    while (words_in != words_pushed || pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr[4:3])
      REG_LENGTH: len_reg = data[LEN_REG_W-1:0];
      REG_LOW:    pat_lo  = data;
      REG_HIGH:   pat_hi  = data;
      default:    ;   // unmapped index is dropped
    endcase
  endtask

  task automatic check_reg(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
    logic [CFG_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      report($sformatf("register 0x%02h read %016h, expected %016h", addr, got, want));
  endtask

  // length word carries random junk above the 5-bit field
  task automatic configure(input logic [LEN_REG_W-1:0] len, input logic [CFG_W-1:0] lo,
                           input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[LEN_REG_W-1:0] = len;
    write_reg(ADDR_LENGTH, len_word);
    write_reg(ADDR_LOW, lo);
    write_reg(ADDR_HIGH, hi);
    check_reg(ADDR_LENGTH, CFG_W'(len));
    check_reg(ADDR_LOW, lo);
    check_reg(ADDR_HIGH, hi);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // driver: offers queued words at the falling edge, holds until taken
  // ---------------------------------------------------------------------
  seq_word_t tx_word;
  bit        tx_loaded = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || words_in == words_offered) begin
      if (!tx_loaded && seq_words.size() != 0) begin
        tx_word   = seq_words.pop_front();
        tx_loaded = 1'b1;
      end
      if (tx_loaded && tx_word.gap == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tx_word.symbol;
        s_axis_tlast  <= tx_word.last;
        tx_loaded     = 1'b0;
        words_offered++;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (tx_loaded) tx_word.gap--;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: random wait after each result word, plus the long hold-off
  // ---------------------------------------------------------------------
  int rx_wait    = 0;
  int rx_taken   = 0;
  int hold_count = 0;
  int hold_served = 0;
  logic rx_hold  = 1'b0;

  // hold-off counter runs on its own so the sender keeps pushing meanwhile
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_count  = HOLD_CYCLES;
    end
    if (hold_count > 0) hold_count--;
    rx_hold <= (hold_count > 0);
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (words_out != rx_taken) begin
        rx_taken = words_out;
        rx_wait  = $urandom_range(0, rx_gap_max);
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_wait != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // ---------------------------------------------------------------------
  result_t due;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        score_window_word(s_axis_tdata, s_axis_tlast);
        words_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (pending_results.size() == 0) begin
          report("result word arrived with nothing outstanding");
        end else begin
          due = pending_results.pop_front();
          if (m_axis_tdata[6:0] !== due.score)
            report($sformatf("result %0d best_score %0d, expected %0d", words_out,
                             $signed(m_axis_tdata[6:0]), $signed(due.score)));
          if (m_axis_tdata[38:7] !== due.location)
            report($sformatf("result %0d best_location %0d, expected %0d", words_out,
                             m_axis_tdata[38:7], due.location));
          if (m_axis_tuser !== due.no_window)
            report($sformatf("result %0d no_window %b, expected %b", words_out,
                             m_axis_tuser, due.no_window));
          if (m_axis_tdata[39] !== 1'b0)
            report($sformatf("result %0d pad bit set", words_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d words in, %0d results out, %0d outstanding",
               words_in, words_out, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    int               phase;
    int               random_words;
    int               nseq;
    int               seq_len;
    int               bias;
    int               offset;
    int               n;
    int               pick;
    logic             open_end;
    logic [4:0]       len_pick;
    logic [CFG_W-1:0] lo_pick;
    logic [CFG_W-1:0] hi_pick;
    logic [7:0]       alpha0;
    logic [7:0]       alpha1;
    logic [7:0]       pb;
    logic [7:0]       sym;

    phase        = 0;
    random_words = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset values: length 3, pattern all zero
    check_reg(ADDR_LENGTH, CFG_W'(LEN_RESET));
    check_reg(ADDR_LOW, '0);
    check_reg(ADDR_HIGH, '0);

    // single byte, shorter than the pattern
    push_word(8'hFF, 1'b1);
    // two equal windows: the later one must win
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b1);
    wait_idle();

    // one-symbol pattern, then a write to an unmapped index that must be dropped
    configure(5'd1, 64'h0000_0000_0000_00FF, '0);
    write_reg(ADDR_SPARE, {$urandom, $urandom});
    push_word(8'hFF, 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'h7F, 1'b1);   // both windows -3, tie goes to start 1
    wait_idle();

    // full 16-symbol pattern matched exactly
    configure(5'd16, '1, '0);
    for (int k = 0; k < 16; k++) push_word((k < 8) ? 8'hFF : 8'h00, k == 15);
    wait_idle();

    // random phases: fresh settings, mostly well-formed sequences biased toward matches
    while (random_words < RANDOM_WORDS) begin
      phase++;
      pick = $urandom_range(0, 9);
      case (pick)
        0:       len_pick = 5'd0;                           // reads as one
        1:       len_pick = 5'd1;
        2:       len_pick = 5'd16;
        3:       len_pick = 5'($urandom_range(17, 31));     // clamps to 16
        default: len_pick = 5'($urandom_range(2, 15));
      endcase
      alpha0 = 8'($urandom);
      alpha1 = 8'($urandom);
      pick   = $urandom_range(0, 2);
      for (int j = 0; j < 16; j++) begin
        case (pick)
          0:       pb = 8'($urandom);
          1:       pb = $urandom_range(0, 1) ? alpha0 : alpha1;
          default: pb = alpha0;
        endcase
        if (j < 8) lo_pick[8*j +: 8] = pb;
        else hi_pick[8*(j-8) +: 8] = pb;
      end
      // an open sequence from the previous phase carries over into this setting
      configure(len_pick, lo_pick, hi_pick);
      n = active_length();
      tx_gap_max = $urandom_range(0, 1) ? 7 : 0;
      rx_gap_max = $urandom_range(0, 1) ? 7 : 0;

      if (phase == 3) begin
        // back pressure: receiver stalls while short sequences pour in
        tx_gap_max = 0;
        rx_gap_max = 0;
        @(posedge clk);
        hold_requests++;
        for (int s = 0; s < 30; s++) begin
          seq_len = $urandom_range(1, 3);
          for (int k = 0; k < seq_len; k++) begin
            push_word(8'($urandom), k == seq_len - 1);
            random_words++;
          end
        end
      end else begin
        nseq = $urandom_range(3, 8);
        for (int s = 0; s < nseq; s++) begin
          pick = $urandom_range(0, 9);
          if (pick < 6) seq_len = $urandom_range(1, n + 4);
          else if (pick < 9) seq_len = $urandom_range(n, 3 * n + 8);
          else seq_len = $urandom_range(30, 60);
          open_end = (s == nseq - 1) && ($urandom_range(0, 4) == 0);
          bias     = $urandom_range(0, 4);     // 0 is pure noise, 4 pure pattern
          offset   = $urandom_range(0, n - 1);
          for (int k = 0; k < seq_len; k++) begin
            if ($urandom_range(0, 3) < bias) sym = pattern_byte((k + offset) % n);
            else sym = 8'($urandom);
            push_word(sym, (k == seq_len - 1) && !open_end);
            random_words++;
          end
        end
      end
      wait_idle();
    end

    wait_idle();
    if (pending_results.size() != 0)
      report($sformatf("%0d results never arrived", pending_results.size()));
    $display("run covered %0d sequence words and %0d result words over %0d pattern settings",
             words_in, words_out, settings_used);
    $display("including length extremes, ties, short sequences and a long receiver stall");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/uwms_pkg.sv
rtl/uwms_cell.sv
rtl/uwms_best.sv
rtl/ungapped_window_match_scorer_core.sv
tb/ungapped_window_match_scorer_core_test.sv
